/* sv/servo_status_frame_receiver_macros.svh */
// Assertion macros shared by the servo status frame receiver modules
`ifndef SERVO_STATUS_FRAME_RECEIVER_MACROS_SVH
`define SERVO_STATUS_FRAME_RECEIVER_MACROS_SVH

// combinational property sampled on every clock edge out of reset
`define SSFR_ASSERT_HOLD(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ssfr assertion failed");

// antecedent in one cycle implies consequent in the next
`define SSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssfr assertion failed");

`endif

/* sv/ssfr_pkg.sv */
// Types and constants of the servo status frame receiver
`default_nettype none

package ssfr_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET = 8'd15;
  localparam logic [7:0] MIN_LEN       = 8'd2;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_BYTE  = 2'd1,
    FN_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_FRAME    = 3'd2,
    ST_ID       = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [7:0] reply_id;
    logic [5:0] expected_count;
    logic       check_count;
  } in_req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] param_byte;
    logic [5:0] param_index;
    logic [2:0] status_code;
    logic [5:0] param_total;
  } out_req_t;

endpackage

`default_nettype wire

/* sv/servo_status_frame_receiver.sv */
// A request is held in the input register, and its result then sits in the output register.
// Throughput: one request per cycle; the input register and result register are the
// only stages, so a request advances whenever the result register is free or drained.
// Reset: asynchronous, active low; parser idle, byte timeout register back to 15.
// Requests that cause no result pass through without occupying the output.
`default_nettype none

`include "servo_status_frame_receiver_macros.svh"

module servo_status_frame_receiver #(
  parameter int MAX_FRAME_LEN = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ssfr_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ssfr_pkg::out_req_t     out_req_o,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i
);

  logic               in_full_q, in_full_d;
  ssfr_pkg::in_req_t  in_item_q;
  logic               out_valid_q, out_valid_d;
  ssfr_pkg::out_req_t out_req_q;
  logic [7:0]         timeout_q;
  logic               advance;
  logic               accept;
  logic               res_valid;
  ssfr_pkg::out_req_t res;

  assign advance    = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_full_d = in_full_q;
    if (accept) begin
      in_full_d = 1'b1;
    end else if (advance) begin
      in_full_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ssfr_parse #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_item_q),
    .timeout_i  (timeout_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= ssfr_pkg::TIMEOUT_RESET;
    end else begin
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_req_i;
    end
    if (advance) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  `SSFR_ASSERT_HOLD(a_stall_cause, !in_stall_o || (in_full_q && out_valid_q && out_stall_i))
  `SSFR_ASSERT_NEXT(a_out_held, out_valid_q && out_stall_i, out_valid_q && $stable(out_req_q))
  `SSFR_ASSERT_NEXT(a_take_fills, accept, in_full_q)

endmodule

`default_nettype wire

/* sv/ssfr_parse.sv */
// Frame parser: transaction state and result of one request per step
`default_nettype none

`include "servo_status_frame_receiver_macros.svh"

module ssfr_parse #(
  parameter int MAX_FRAME_LEN = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire ssfr_pkg::in_req_t item_i,
  input  wire logic [7:0]        timeout_i,
  output logic                   res_valid_o,
  output ssfr_pkg::out_req_t     res_o
);

  localparam logic [7:0] MAX_LEN_B = 8'(MAX_FRAME_LEN);

  ssfr_pkg::phase_e phase_q, phase_d;
  logic [6:0] byte_count_q, byte_count_d;
  logic       header_bad_q, header_bad_d;
  logic [7:0] frame_id_q, frame_id_d;
  logic [6:0] frame_len_q, frame_len_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] wait_ticks_q, wait_ticks_d;
  logic [7:0] want_id_q, want_id_d;
  logic [5:0] want_count_q, want_count_d;
  logic       count_check_q, count_check_d;

  logic [7:0] rx_b;
  logic       is_hdr;
  logic       head_fail;
  logic [2:0] head_code;
  logic       body_last;
  logic [6:0] total;
  logic       sum_ok;
  logic       count_bad;
  logic [7:0] wait_inc;
  logic       tick_out;
  logic       armed;

  assign rx_b      = item_i.rx_byte;
  assign is_hdr    = (rx_b == ssfr_pkg::HDR_BYTE);
  assign armed     = (phase_q != ssfr_pkg::PH_IDLE);
  assign head_fail = header_bad_q || (frame_id_q != want_id_q) ||
                     (rx_b < ssfr_pkg::MIN_LEN) || (rx_b > MAX_LEN_B);
  assign head_code = header_bad_q                ? ssfr_pkg::ST_FRAME :
                     (frame_id_q != want_id_q)   ? ssfr_pkg::ST_ID    :
                                                   ssfr_pkg::ST_FRAME;
  assign body_last = ({1'b0, byte_count_q} + 8'd1) >= {1'b0, frame_len_q};
  assign total     = frame_len_q - 7'd2;
  assign sum_ok    = (~running_sum_q == rx_b);
  assign count_bad = count_check_q && (total != {1'b0, want_count_q});
  assign wait_inc  = (wait_ticks_q == 8'hFF) ? wait_ticks_q : wait_ticks_q + 8'd1;
  assign tick_out  = (wait_inc >= timeout_i);

  // next state
  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    header_bad_d  = header_bad_q;
    frame_id_d    = frame_id_q;
    frame_len_d   = frame_len_q;
    running_sum_d = running_sum_q;
    wait_ticks_d  = wait_ticks_q;
    want_id_d     = want_id_q;
    want_count_d  = want_count_q;
    count_check_d = count_check_q;
    if (step_i) begin
      case (item_i.func)
        ssfr_pkg::FN_START: begin
          want_id_d     = item_i.reply_id;
          want_count_d  = item_i.expected_count;
          count_check_d = item_i.check_count;
          phase_d       = ssfr_pkg::PH_HEAD;
          byte_count_d  = 7'd0;
          header_bad_d  = 1'b0;
          wait_ticks_d  = 8'd0;
          running_sum_d = 8'd0;
        end
        ssfr_pkg::FN_BYTE: begin
          if (phase_q == ssfr_pkg::PH_HEAD) begin
            wait_ticks_d = 8'd0;
            case (byte_count_q)
              7'd0: begin
                header_bad_d = !is_hdr;
                byte_count_d = 7'd1;
              end
              7'd1: begin
                header_bad_d = header_bad_q | !is_hdr;
                byte_count_d = 7'd2;
              end
              7'd2: begin
                frame_id_d   = rx_b;
                byte_count_d = 7'd3;
              end
              default: begin
                if (head_fail) begin
                  phase_d = ssfr_pkg::PH_IDLE;
                end else begin
                  frame_len_d   = rx_b[6:0];
                  running_sum_d = frame_id_q + rx_b;
                  phase_d       = ssfr_pkg::PH_BODY;
                  byte_count_d  = 7'd0;
                end
              end
            endcase
          end else if (phase_q == ssfr_pkg::PH_BODY) begin
            wait_ticks_d = 8'd0;
            if (body_last) begin
              phase_d = ssfr_pkg::PH_IDLE;
            end else begin
              running_sum_d = running_sum_q + rx_b;
              byte_count_d  = byte_count_q + 7'd1;
            end
          end
        end
        ssfr_pkg::FN_TICK: begin
          if (armed) begin
            wait_ticks_d = wait_inc;
            if (tick_out) begin
              phase_d = ssfr_pkg::PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && armed) begin
      case (item_i.func)
        ssfr_pkg::FN_BYTE: begin
          if (phase_q == ssfr_pkg::PH_HEAD) begin
            if (byte_count_q > 7'd2 && head_fail) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = ssfr_pkg::KIND_STATUS;
              res_o.status_code = head_code;
            end
          end else if (body_last) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = ssfr_pkg::KIND_STATUS;
            if (!sum_ok) begin
              res_o.status_code = ssfr_pkg::ST_CHECKSUM;
            end else if (count_bad) begin
              res_o.status_code = ssfr_pkg::ST_FRAME;
            end else begin
              res_o.status_code = ssfr_pkg::ST_OK;
              res_o.param_total = total[5:0];
            end
          end else if (byte_count_q != 7'd0) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = ssfr_pkg::KIND_PARAM;
            res_o.param_byte  = rx_b;
            res_o.param_index = 6'(byte_count_q - 7'd1);
          end
        end
        ssfr_pkg::FN_TICK: begin
          if (tick_out) begin
            res_valid_o       = 1'b1;
            res_o.result_kind = ssfr_pkg::KIND_STATUS;
            res_o.status_code = ssfr_pkg::ST_TIMEOUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= ssfr_pkg::PH_IDLE;
      byte_count_q  <= '0;
      header_bad_q  <= 1'b0;
      frame_id_q    <= '0;
      frame_len_q   <= '0;
      running_sum_q <= '0;
      wait_ticks_q  <= '0;
      want_id_q     <= '0;
      want_count_q  <= '0;
      count_check_q <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      header_bad_q  <= header_bad_d;
      frame_id_q    <= frame_id_d;
      frame_len_q   <= frame_len_d;
      running_sum_q <= running_sum_d;
      wait_ticks_q  <= wait_ticks_d;
      want_id_q     <= want_id_d;
      want_count_q  <= want_count_d;
      count_check_q <= count_check_d;
    end
  end

  `SSFR_ASSERT_HOLD(a_body_len, (phase_q != ssfr_pkg::PH_BODY) ||
    ((frame_len_q >= 7'd2) && ({1'b0, frame_len_q} <= MAX_LEN_B)))
  `SSFR_ASSERT_HOLD(a_head_count, (phase_q != ssfr_pkg::PH_HEAD) || (byte_count_q <= 7'd3))
  `SSFR_ASSERT_NEXT(a_status_ends,
    step_i && res_valid_o && (res_o.result_kind == ssfr_pkg::KIND_STATUS),
    phase_q == ssfr_pkg::PH_IDLE)

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for the servo status frame receiver: table-driven and random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfr_pkg::*;

  localparam int         MAX_LEN       = 64;
  localparam int         PHASE_ITEMS   = 300;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam logic [1:0] FN_RESERVED   = 2'd3;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PARAM,
    CHK_STATUS
  } row_check_e;

  typedef enum int {
    FLAW_HEADER,
    FLAW_ID,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_SUM,
    FLAW_CUT,
    FLAW_TIMEOUT,
    FLAW_NONE
  } flaw_e;

  typedef struct {
    logic [1:0] fn;
    logic [7:0] data;
    logic [5:0] cnt;
    logic       chk;
    row_check_e check;
    logic [7:0] want_byte;
    logic [5:0] want_num;
    status_e    want_code;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_req_t out_req_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  // parser mirror
  phase_e     parse_phase;
  logic [6:0] pos;
  logic       hdr_bad;
  logic [7:0] got_id;
  logic [6:0] got_len;
  logic [7:0] sum;
  logic [7:0] ticks;
  logic [7:0] want_id;
  logic [5:0] want_cnt;
  logic       cnt_check;
  logic [7:0] timeout_limit;

  out_req_t expected_results [$];
  int       fail_count;
  int       items_done;
  int       cycle_count;
  bit       idling_on;
  bit       in_gaps;

  dir_row_t directed_rows [23] = '{
    '{FN_BYTE,     8'h00, 6'd0,  1'b0, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_TICK,     8'h00, 6'd0,  1'b0, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_RESERVED, 8'h00, 6'd0,  1'b0, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_START,    8'h01, 6'd1,  1'b1, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h01, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h03, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hAB, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_PARAM,  8'hFF, 6'd0, ST_OK},
    '{FN_BYTE,     8'h51, 6'd0,  1'b0, CHK_STATUS, 8'h00, 6'd1, ST_OK},
    '{FN_START,    8'hFF, 6'd62, 1'b0, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    // restart while armed
    '{FN_START,    8'h00, 6'd0,  1'b1, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h00, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h00, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h02, 6'd0,  1'b0, CHK_STATUS, 8'h00, 6'd0, ST_FRAME},
    '{FN_START,    8'h80, 6'd62, 1'b1, CHK_NONE,   8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'hFF, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    '{FN_BYTE,     8'h7F, 6'd0,  1'b0, CHK_MODEL,  8'h00, 6'd0, ST_OK},
    // ID is judged before the out-of-range length
    '{FN_BYTE,     8'h41, 6'd0,  1'b0, CHK_STATUS, 8'h00, 6'd0, ST_ID}
  };

  servo_status_frame_receiver #(
    .MAX_FRAME_LEN(MAX_LEN)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit finish_frame(input status_e code, input logic [5:0] total,
                                      output out_req_t res);
    res = '0;
    res.result_kind = KIND_STATUS;
    res.status_code = code;
    res.param_total = total;
    parse_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit predict_reply(input in_req_t r, output out_req_t res,
                                       output bit taken);
    logic [7:0] b;
    logic [6:0] total;
    res   = '0;
    taken = 1'b1;
    b     = r.rx_byte;
    if (r.func == FN_START) begin
      want_id     = r.reply_id;
      want_cnt    = r.expected_count;
      cnt_check   = r.check_count;
      parse_phase = PH_HEAD;
      pos         = '0;
      hdr_bad     = 1'b0;
      ticks       = '0;
      sum         = '0;
      return 1'b0;
    end
    if (parse_phase == PH_IDLE || r.func == FN_RESERVED) begin
      taken = 1'b0;
      return 1'b0;
    end
    if (r.func == FN_TICK) begin
      if (ticks != 8'hFF) ticks++;
      if (ticks >= timeout_limit) return finish_frame(ST_TIMEOUT, '0, res);
      return 1'b0;
    end
    ticks = '0;
    if (parse_phase == PH_HEAD) begin
      case (pos)
        7'd0: hdr_bad = (b != HDR_BYTE);
        7'd1: hdr_bad = hdr_bad | (b != HDR_BYTE);
        7'd2: got_id = b;
        default: begin
          if (hdr_bad) return finish_frame(ST_FRAME, '0, res);
          if (got_id != want_id) return finish_frame(ST_ID, '0, res);
          if (b < MIN_LEN || int'(b) > MAX_LEN) return finish_frame(ST_FRAME, '0, res);
          got_len     = b[6:0];
          sum         = got_id + b;
          parse_phase = PH_BODY;
          pos         = '0;
          return 1'b0;
        end
      endcase
      pos++;
      return 1'b0;
    end
    // body: error byte, parameters, checksum
    if (pos + 7'd1 >= got_len) begin
      total = got_len - 7'd2;
      if (~sum != b) return finish_frame(ST_CHECKSUM, '0, res);
      if (cnt_check && total != {1'b0, want_cnt}) return finish_frame(ST_FRAME, '0, res);
      return finish_frame(ST_OK, total[5:0], res);
    end
    sum = sum + b;
    if (pos == '0) begin
      pos = 7'd1;
      return 1'b0;
    end
    res.result_kind = KIND_PARAM;
    res.param_byte  = b;
    res.param_index = 6'(pos - 7'd1);
    pos++;
    return 1'b1;
  endfunction

  function automatic in_req_t random_request(input logic [1:0] fn);
    in_req_t r;
    r.func           = fn;
    r.rx_byte        = 8'($urandom);
    r.reply_id       = 8'($urandom);
    r.expected_count = 6'($urandom_range(0, 62));
    r.check_count    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(input in_req_t r, output bit produced, output out_req_t res,
                              output bit taken);
    if (in_gaps && idling_on && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    produced = predict_reply(r, res, taken);
    @(negedge clk_i);
  endtask

  task automatic issue(input in_req_t r);
    bit       produced;
    bit       taken;
    out_req_t res;
    send_request(r, produced, res, taken);
    if (produced) expected_results.push_back(res);
    if (taken) items_done++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_limit = value;
  endtask

  task automatic run_frame();
    logic [7:0] frame [$];
    logic [7:0] fsum;
    logic [7:0] fid;
    logic [7:0] flen;
    logic [7:0] b;
    int         n_par;
    int         sel;
    int         stop;
    int         gap_max;
    flaw_e      flaw;
    in_req_t    r;
    sel = $urandom_range(0, 19);
    if (sel == 0) n_par = MAX_LEN - 2;
    else if (sel == 1) n_par = 0;
    else if (sel == 2) n_par = $urandom_range(0, MAX_LEN - 2);
    else n_par = $urandom_range(1, 6);
    sel  = $urandom_range(0, 19);
    flaw = (sel < int'(FLAW_NONE)) ? flaw_e'(sel) : FLAW_NONE;
    if (flaw == FLAW_TIMEOUT && timeout_limit > 8'd32) flaw = FLAW_CUT;
    in_gaps = ($urandom_range(0, 3) != 0);
    fid  = 8'($urandom);
    flen = 8'(n_par + 2);

    r = random_request(FN_START);
    r.reply_id = (flaw == FLAW_ID) ? fid ^ 8'($urandom_range(1, 255)) : fid;
    if ($urandom_range(0, 1) == 1) r.expected_count = 6'(n_par);
    issue(r);

    frame = '{HDR_BYTE, HDR_BYTE, fid, flen};
    fsum  = fid + flen;
    repeat (n_par + 1) begin
      b = 8'($urandom);
      fsum = fsum + b;
      frame.push_back(b);
    end
    frame.push_back(~fsum);
    case (flaw)
      FLAW_HEADER: frame[$urandom_range(0, 1)] = 8'($urandom_range(0, 254));
      FLAW_SHORT: begin
        frame[3] = 8'($urandom_range(0, 1));
        frame    = frame[0:3];
      end
      FLAW_LONG: begin
        frame[3] = 8'($urandom_range(MAX_LEN + 1, 255));
        frame    = frame[0:3];
      end
      FLAW_SUM: frame[frame.size() - 1] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    stop = (flaw == FLAW_CUT || flaw == FLAW_TIMEOUT) ?
           $urandom_range(0, frame.size() - 1) : frame.size();
    gap_max = (timeout_limit > 8'd7) ? 6 : int'(timeout_limit) - 1;

    for (int i = 0; i < stop; i++) begin
      if (gap_max > 0 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, gap_max)) issue(random_request(FN_TICK));
      end
      r = random_request(FN_BYTE);
      r.rx_byte = frame[i];
      issue(r);
    end
    if (flaw == FLAW_TIMEOUT) begin
      repeat (int'(timeout_limit)) issue(random_request(FN_TICK));
    end
  endtask

  task automatic run_noise();
    in_gaps = 1'b1;
    repeat ($urandom_range(1, 4)) issue(random_request(2'($urandom_range(0, 3))));
  endtask

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : check_results
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result kind=%0d byte=%02h idx=%0d code=%0d total=%0d",
                              out_req_o.result_kind, out_req_o.param_byte,
                              out_req_o.param_index, out_req_o.status_code,
                              out_req_o.param_total));
      end else begin
        want = expected_results.pop_front();
        if (out_req_o.result_kind !== want.result_kind ||
            out_req_o.param_byte  !== want.param_byte  ||
            out_req_o.param_index !== want.param_index ||
            out_req_o.status_code !== want.status_code ||
            out_req_o.param_total !== want.param_total) begin
          log_failure($sformatf({"mismatch: exp kind=%0d byte=%02h idx=%0d code=%0d total=%0d",
                                 " got kind=%0d byte=%02h idx=%0d code=%0d total=%0d"},
                                want.result_kind, want.param_byte, want.param_index,
                                want.status_code, want.param_total,
                                out_req_o.result_kind, out_req_o.param_byte,
                                out_req_o.param_index, out_req_o.status_code,
                                out_req_o.param_total));
        end
      end
    end
  end

  // output-side back-pressure
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(40, 150)) @(negedge clk_i);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run
    logic [7:0] plan [6];
    dir_row_t   row;
    in_req_t    r;
    out_req_t   res;
    out_req_t   typed;
    bit         produced;
    bit         taken;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    fail_count    = 0;
    items_done    = 0;
    cycle_count   = 0;
    idling_on     = 1'b1;
    in_gaps       = 1'b1;
    parse_phase   = PH_IDLE;
    pos           = '0;
    hdr_bad       = 1'b0;
    got_id        = '0;
    got_len       = '0;
    sum           = '0;
    ticks         = '0;
    want_id       = '0;
    want_cnt      = '0;
    cnt_check     = 1'b0;
    timeout_limit = TIMEOUT_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      r = '0;
      r.func = row.fn;
      if (row.fn == FN_START) begin
        r.reply_id       = row.data;
        r.expected_count = row.cnt;
        r.check_count    = row.chk;
      end else begin
        r.rx_byte = row.data;
      end
      send_request(r, produced, res, taken);
      typed = '0;
      case (row.check)
        CHK_MODEL: if (produced) expected_results.push_back(res);
        CHK_PARAM: begin
          typed.result_kind = KIND_PARAM;
          typed.param_byte  = row.want_byte;
          typed.param_index = row.want_num;
          expected_results.push_back(typed);
        end
        CHK_STATUS: begin
          typed.result_kind = KIND_STATUS;
          typed.status_code = row.want_code;
          typed.param_total = row.want_num;
          expected_results.push_back(typed);
        end
        default: ;
      endcase
    end
    settle();

    plan = '{8'd1, 8'd255, 8'($urandom_range(3, 254)), 8'd2,
             8'($urandom_range(3, 32)), 8'($urandom_range(3, 254))};
    foreach (plan[p]) begin
      write_timeout(plan[p]);
      if (p == $size(plan) - 1) idling_on = 1'b0;
      items_done = 0;
      while (items_done < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) run_noise();
        else run_frame();
      end
      settle();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ssfr_pkg.sv
sv/ssfr_parse.sv
sv/servo_status_frame_receiver.sv
tb/sv/testbench.sv
